// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Clock and reset are passed in by the user of each macro.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at each rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked at each rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/mpv_pkg.sv =====
// Package for the Merkle path checker: SM3 constants, item codes, helpers.
// No dependencies.
`default_nettype none
package mpv_pkg;
	localparam int MAX_PATH_DEF = 32;

	localparam logic [1:0] KIND_LEAF    = 2'd0;
	localparam logic [1:0] KIND_SIBLING = 2'd1;
	localparam logic [1:0] KIND_ROOT    = 2'd2;

	localparam logic [255:0] SM3_IV = {
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

	typedef struct packed {
		logic       start;
		logic [1:0] kind;
	} sm3_ctl_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	function automatic logic [7:0] hexc(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h61 + {4'd0, n} - 8'd10);
	endfunction
endpackage
`default_nettype wire

// ===== hdl/mpv_if.sv =====
// Valid/ready channel carrying a payload of parametric type.
// Depends on nothing.
`default_nettype none
interface mpv_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/mpv_sm3.sv =====
// Iterative SM3 engine: one round a cycle, message expansion in a 16-word window.
// Builds the two padded blocks of the hex text of a 257-bit sum. Uses mpv_pkg.
`default_nettype none
module mpv_sm3 import mpv_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [256:0] sum,
	output logic              done,
	output logic [255:0]      digest
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RND  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]   state_q;
	logic         blk_q;
	logic [6:0]   rnd_q;
	logic [256:0] sum_q;
	logic [31:0]  win_q [16];
	logic [31:0]  v_q [8];
	logic [31:0]  r_q [8];

	// Message block words from the stored sum
	logic [1023:0] text;
	always_comb begin
		text = '0;
		if (sum_q[256]) begin
			text[1023:1016] = 8'h31;
			for (int i = 0; i < 64; i++)
				text[1015 - 8*i -: 8] = hexc(sum_q[255 - 4*i -: 4]);
			text[503:496] = 8'h80;
			text[63:0] = 64'd520;
		end else begin
			for (int i = 0; i < 64; i++)
				text[1023 - 8*i -: 8] = hexc(sum_q[255 - 4*i -: 4]);
			text[511:504] = 8'h80;
			text[63:0] = 64'd512;
		end
	end

	logic [31:0] w0, w4, wn, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
	logic        hi;
	always_comb begin
		hi  = rnd_q >= 7'd16;
		w0  = win_q[0];
		w4  = win_q[4];
		wn  = p1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15)) ^ rotl(win_q[3], 5'd7)
			^ win_q[10];
		tj  = rotl(hi ? 32'h7a879d8a : 32'h79cc4519, rnd_q[4:0]);
		a12 = rotl(r_q[0], 5'd12);
		ss1 = rotl(a12 + r_q[4] + tj, 5'd7);
		ss2 = ss1 ^ a12;
		ff  = hi ? ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]))
			: (r_q[0] ^ r_q[1] ^ r_q[2]);
		gg  = hi ? ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6])) : (r_q[4] ^ r_q[5] ^ r_q[6]);
		tt1 = ff + r_q[3] + ss2 + (w0 ^ w4);
		tt2 = gg + r_q[7] + ss1 + w0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			blk_q   <= 1'b0;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_FIN;
					blk_q   <= 1'b0;
				end
				S_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd63)
						state_q <= S_FIN;
				end
				S_FIN: begin
					rnd_q <= '0;
					if (blk_q && rnd_q == 7'd64)
						state_q <= S_IDLE;
					else
						state_q <= S_RND;
					if (rnd_q == 7'd64)
						blk_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: S_FIN folds the last round into the chain and loads the next block
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			sum_q <= sum;
			for (int i = 0; i < 8; i++)
				v_q[i] <= SM3_IV[255 - 32*i -: 32];
		end else if (state_q == S_RND) begin
			for (int i = 0; i < 15; i++)
				win_q[i] <= win_q[i + 1];
			win_q[15] <= wn;
			r_q[0] <= tt1; r_q[1] <= r_q[0]; r_q[2] <= rotl(r_q[1], 5'd9); r_q[3] <= r_q[2];
			r_q[4] <= p0(tt2); r_q[5] <= r_q[4]; r_q[6] <= rotl(r_q[5], 5'd19);
			r_q[7] <= r_q[6];
		end else if (state_q == S_FIN) begin
			for (int i = 0; i < 16; i++)
				win_q[i] <= text[(rnd_q == 7'd64 ? 511 : 1023) - 32*i -: 32];
			for (int i = 0; i < 8; i++) begin
				if (rnd_q == 7'd64) begin
					v_q[i] <= v_q[i] ^ r_q[i];
					r_q[i] <= v_q[i] ^ r_q[i];
				end else
					r_q[i] <= v_q[i];
			end
		end
	end

	assign done = state_q == S_FIN && blk_q && rnd_q == 7'd64;
	always_comb
		for (int i = 0; i < 8; i++)
			digest[255 - 32*i -: 32] = v_q[i] ^ r_q[i];
endmodule
`default_nettype wire

// ===== hdl/merkle_path_verify_sm3_core.sv =====
// Merkle path checker with SM3: leaf, sibling and root items in, one result per root.
// Leaf and root items are registered on transfer, a root into the output register; a
// sibling keeps ready low until its busy flag clears after two SM3 compressions of 64
// rounds, one round a cycle in the shared round unit, each after a block load.
// Throughput: one item at a time; ready is low while a sibling is being hashed.
// Reset clears the running value, the path counter, the flags and the result register.
`default_nettype none
module merkle_path_verify_sm3_core import mpv_pkg::*; #(
	parameter int MAX_PATH = MAX_PATH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mpv_if.sink       in_ch,
	mpv_if.source     out_ch
);
	logic [255:0] run_q;
	logic         leaf_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic         ovalid_q;
	logic [7:0]   res_q;

	logic [257:0] pin;
	logic [255:0] given;
	logic         acc, done;
	logic [255:0] dig;
	sm3_ctl_t     ctl;

	assign pin   = in_ch.data;
	assign given = pin[255:0];
	assign in_ch.ready = !busy_q && (!ovalid_q || out_ch.ready);
	assign acc   = in_ch.valid && in_ch.ready;
	assign ctl.kind  = pin[257:256];
	assign ctl.start = acc && ctl.kind == KIND_SIBLING;

	mpv_sm3 u_sm3 (
		.clk(clk), .arst_n(arst_n), .start(ctl.start),
		.sum({1'b0, run_q} + {1'b0, given}), .done(done), .digest(dig)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0; leaf_q <= 1'b0; cnt_q <= '0; busy_q <= 1'b0; ovalid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (out_ch.ready)
				ovalid_q <= 1'b0;
			if (done) begin
				run_q  <= dig;
				busy_q <= 1'b0;
			end
			if (acc) begin
				unique case (ctl.kind)
					KIND_LEAF: begin
						run_q <= given; leaf_q <= 1'b1; cnt_q <= '0;
					end
					KIND_SIBLING: begin
						busy_q <= 1'b1;
						if (cnt_q < 6'(MAX_PATH))
							cnt_q <= cnt_q + 6'd1;
					end
					KIND_ROOT: begin
						res_q <= {run_q == given, cnt_q, !leaf_q};
						ovalid_q <= 1'b1; leaf_q <= 1'b0; cnt_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = res_q;
endmodule
`default_nettype wire

// ===== hdl/mpv_checker.sv =====
// Port checker for the Merkle path core, bound to the top level.
// Uses assert_macros.svh and mpv_pkg.
`default_nettype none
`include "assert_macros.svh"
module mpv_checker import mpv_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] in_kind,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_data
);
	`ASSERT_NEXT(a_sib_busy, clk, arst_n, in_valid && in_ready && in_kind == KIND_SIBLING, !in_ready)
	`ASSERT_NEXT(a_root_out, clk, arst_n, in_valid && in_ready && in_kind == KIND_ROOT, out_valid)
	`ASSERT_IMPL(a_len_max, clk, arst_n, out_valid, out_data[6:1] <= 6'd63)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind merkle_path_verify_sm3_core mpv_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.in_kind(in_ch.data[257:256]), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data(out_ch.data)
);
`default_nettype wire
